// ===== sv/bitmap_font_text_blitter_macros.svh =====
// bitmap_font_text_blitter_macros.svh: assertion shorthands for the text blitter
// used by the blitter top level and the glyph scanner, no other dependencies
`ifndef BITMAP_FONT_TEXT_BLITTER_MACROS_SVH
`define BITMAP_FONT_TEXT_BLITTER_MACROS_SVH

// same-cycle implication
`define BFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfb_pkg.sv =====
// bfb_pkg: types and constants shared by the bitmap font text blitter
// no dependencies
`timescale 1ns / 1ps

package bfb_pkg;

    // request codes
    localparam logic [2:0] FUNC_LOAD_MAP   = 3'd0;
    localparam logic [2:0] FUNC_LOAD_ADV   = 3'd1;
    localparam logic [2:0] FUNC_LOAD_GLYPH = 3'd2;
    localparam logic [2:0] FUNC_START      = 3'd3;
    localparam logic [2:0] FUNC_CHAR       = 3'd4;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_TOP    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_BAND_BOTTOM = 1'd1;

    localparam logic [7:0]  BAND_BOTTOM_RESET = 8'd199;
    localparam logic [8:0]  BAND_MARGIN       = 9'd8;
    localparam logic [7:0]  SPACE_CHAR        = 8'h20;
    localparam logic [7:0]  END_CHAR          = 8'h00;
    localparam logic [15:0] SPACE_STEP        = 16'd6;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] index;
        logic [7:0] value;
        logic [8:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] color;
    } bfb_in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_offset;
        logic [7:0]  pixel_color;
        logic [15:0] draw_width;
        logic        last;
    } bfb_out_t;

    // table write request to the font memories
    typedef struct packed {
        logic       map_we;
        logic       adv_we;
        logic       glyph_we;
        logic [9:0] index;
        logic [7:0] data;
    } bfb_wr_t;

    // glyph scan command
    typedef struct packed {
        logic        start;
        logic [15:0] cursor;
    } bfb_scan_cmd_t;

    // pixel offered by the scanner
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] offset;
    } bfb_pix_t;

endpackage

// ===== sv/bfb_font_mem.sv =====
// bfb_font_mem: character map, advance table and glyph bitmap memories
// depends on bfb_pkg
`timescale 1ns / 1ps

module bfb_font_mem import bfb_pkg::*; #(
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 128
) (
    input  logic                                   aclk,
    input  bfb_wr_t                                wr,
    input  logic                                   map_re,
    input  logic [7:0]                             map_raddr,
    output logic [7:0]                             map_rdata,
    input  logic                                   adv_re,
    input  logic [((GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1)-1:0] adv_raddr,
    output logic [7:0]                             adv_rdata,
    input  logic [((GLYPH_COUNT * GLYPH_ROWS > 1) ?
                   $clog2(GLYPH_COUNT * GLYPH_ROWS) : 1)-1:0] glyph_raddr,
    output logic [7:0]                             glyph_rdata
);

    localparam int GI_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int GSTORE  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GADDR_W = (GSTORE > 1) ? $clog2(GSTORE) : 1;

    logic [7:0] map_mem   [256];
    logic [7:0] adv_mem   [GLYPH_COUNT];
    logic [7:0] glyph_mem [GSTORE];

    // character map
    always_ff @(posedge aclk) begin
        if (wr.map_we) begin
            map_mem[wr.index[7:0]] <= wr.data;
        end
        if (map_re) begin
            map_rdata <= map_mem[map_raddr];
        end
    end

    // advance table
    always_ff @(posedge aclk) begin
        if (wr.adv_we) begin
            adv_mem[GI_W'(wr.index)] <= wr.data;
        end
        if (adv_re) begin
            adv_rdata <= adv_mem[adv_raddr];
        end
    end

    // glyph rows, read every cycle
    always_ff @(posedge aclk) begin
        if (wr.glyph_we) begin
            glyph_mem[GADDR_W'(wr.index)] <= wr.data;
        end
        glyph_rdata <= glyph_mem[glyph_raddr];
    end

endmodule

// ===== sv/bfb_glyph_scan.sv =====
// bfb_glyph_scan: bit-serial glyph scanner, one glyph bit per cycle through a row shift register
// while pix_grant keeps up; depends on bfb_pkg and bitmap_font_text_blitter_macros.svh
`timescale 1ns / 1ps
`include "bitmap_font_text_blitter_macros.svh"

module bfb_glyph_scan import bfb_pkg::*; #(
    parameter int LINE_PITCH  = 320,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bfb_scan_cmd_t        cmd,
    input  logic [((GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1)-1:0] glyph,
    output logic [((GLYPH_COUNT * GLYPH_ROWS > 1) ?
                   $clog2(GLYPH_COUNT * GLYPH_ROWS) : 1)-1:0] glyph_raddr,
    input  logic [7:0]           glyph_rdata,
    output bfb_pix_t             pix,
    input  logic                 pix_grant,
    output logic                 done
);

    localparam int GSTORE  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GADDR_W = (GSTORE > 1) ? $clog2(GSTORE) : 1;
    localparam int RC_W    = $clog2(GLYPH_ROWS + 1);
    localparam logic [15:0] PITCH = 16'(LINE_PITCH);

    typedef enum logic [4:0] {
        SC_IDLE  = 5'b00001,
        SC_FETCH = 5'b00010,
        SC_LOAD  = 5'b00100,
        SC_SHIFT = 5'b01000,
        SC_FLUSH = 5'b10000
    } sc_state_t;

    sc_state_t          state_reg, state_next;
    logic [GADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [RC_W-1:0]    rows_left_reg, rows_left_next;
    logic [15:0]        row_base_reg, row_base_next;
    logic [15:0]        col_off_reg, col_off_next;
    logic [2:0]         col_reg, col_next;
    logic [7:0]         bits_reg, bits_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [15:0]        pend_off_reg, pend_off_next;
    logic               step;

    assign glyph_raddr = row_addr_reg;

    // pending pixel goes out when the next set bit or the glyph end shows up
    assign pix.valid  = ((state_reg == SC_SHIFT) && bits_reg[7] && pend_valid_reg) ||
                        ((state_reg == SC_FLUSH) && pend_valid_reg);
    assign pix.last   = (state_reg == SC_FLUSH);
    assign pix.offset = pend_off_reg;

    assign step = (state_reg == SC_SHIFT) &&
                  (!bits_reg[7] || !pend_valid_reg || pix_grant);

    // scan sequencer
    always_comb begin
        state_next      = state_reg;
        row_addr_next   = row_addr_reg;
        rows_left_next  = rows_left_reg;
        row_base_next   = row_base_reg;
        col_off_next    = col_off_reg;
        col_next        = col_reg;
        bits_next       = bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_off_next   = pend_off_reg;
        done            = 1'b0;
        unique case (state_reg)
            SC_IDLE: begin
                if (cmd.start) begin
                    row_addr_next   = GADDR_W'(glyph * GLYPH_ROWS);
                    rows_left_next  = RC_W'(GLYPH_ROWS);
                    row_base_next   = cmd.cursor;
                    pend_valid_next = 1'b0;
                    state_next      = SC_FETCH;
                end
            end
            SC_FETCH: begin
                state_next = SC_LOAD;
            end
            SC_LOAD: begin
                bits_next      = glyph_rdata;
                col_next       = '0;
                col_off_next   = row_base_reg;
                rows_left_next = rows_left_reg - 1'b1;
                if (rows_left_next != '0) begin
                    row_addr_next = row_addr_reg + 1'b1;
                end
                state_next = SC_SHIFT;
            end
            SC_SHIFT: begin
                if (step) begin
                    if (bits_reg[7]) begin
                        pend_valid_next = 1'b1;
                        pend_off_next   = col_off_reg;
                    end
                    bits_next    = {bits_reg[6:0], 1'b0};
                    col_next     = col_reg + 1'b1;
                    col_off_next = col_off_reg + 1'b1;
                    if (col_reg == 3'd7) begin
                        if (rows_left_reg == '0) begin
                            state_next = SC_FLUSH;
                        end else begin
                            // next row was prefetched while this one shifted
                            bits_next      = glyph_rdata;
                            col_next       = '0;
                            row_base_next  = row_base_reg + PITCH;
                            col_off_next   = row_base_reg + PITCH;
                            rows_left_next = rows_left_reg - 1'b1;
                            if (rows_left_next != '0) begin
                                row_addr_next = row_addr_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            SC_FLUSH: begin
                if (!pend_valid_reg || pix_grant) begin
                    pend_valid_next = 1'b0;
                    done            = 1'b1;
                    state_next      = SC_IDLE;
                end
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SC_IDLE;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        row_addr_reg  <= row_addr_next;
        rows_left_reg <= rows_left_next;
        row_base_reg  <= row_base_next;
        col_off_reg   <= col_off_next;
        col_reg       <= col_next;
        bits_reg      <= bits_next;
        pend_off_reg  <= pend_off_next;
    end

    `BFB_ASSERT_NOW(a_start_when_idle, aclk, aresetn, cmd.start, state_reg == SC_IDLE, "scan start while busy")
    `BFB_ASSERT_NEXT(a_done_clears, aclk, aresetn, done, !pend_valid_reg && state_reg == SC_IDLE, "pixel left after glyph end")
    `BFB_ASSERT_NOW(a_idle_no_pend, aclk, aresetn, state_reg == SC_IDLE, !pend_valid_reg, "pending pixel while idle")

endmodule

// ===== sv/bitmap_font_text_blitter.sv =====
// bitmap_font_text_blitter: top level, request decode, string state and result register
// depends on bfb_pkg, bfb_font_mem, bfb_glyph_scan and bitmap_font_text_blitter_macros.svh
`timescale 1ns / 1ps
`include "bitmap_font_text_blitter_macros.svh"

// Usage
// Requests enter on s_valid/s_ready/s_data; results leave on m_valid/m_ready/m_data,
// one registered result at a time. Band limits are written through cfg_wr_en,
// cfg_index and cfg_wdata while the block is idle.
// Per request:
//   table loads give no result
//   start items inside the band: the cursor product pos_y * LINE_PITCH
//   is built one bit of pos_y per cycle by a shift-and-add unit
//   a zero text byte gives its finish result from T_FIN once the result register is free
//   a drawn glyph is scanned by the glyph row shift register, one glyph bit
//   per cycle while the receiver keeps up; the first pixel appears a
//   set bit later, since each pixel is held until the next one or the glyph end
//   marks whether it is the last
// A stalled receiver holds the result register and the scanner waits on it; the
// next request is taken only when the current one is done.
// Reset clears the string state, the cursor, the width and the color; band_top
// becomes 0 and band_bottom 199. Font tables are not cleared and must be loaded.

module bitmap_font_text_blitter import bfb_pkg::*; #(
    parameter int LINE_PITCH  = 320,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfb_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfb_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    localparam int GI_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int GSTORE  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GADDR_W = (GSTORE > 1) ? $clog2(GSTORE) : 1;

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_MUL  = 5'b00010,
        T_MAP  = 5'b00100,
        T_SCAN = 5'b01000,
        T_FIN  = 5'b10000
    } t_state_t;

    t_state_t      state_reg, state_next;
    logic [7:0]    band_top_reg, band_bottom_reg;
    logic [15:0]   cursor_reg, cursor_next;
    logic [15:0]   width_reg, width_next;
    logic [7:0]    ink_reg, ink_next;
    logic          active_reg, active_next;
    logic [15:0]   prod_reg, prod_next;
    logic [15:0]   mcand_reg, mcand_next;
    logic [7:0]    mplier_reg, mplier_next;
    logic          m_valid_reg;
    bfb_out_t      m_data_reg;

    logic          s_fire;
    logic          band_ok;
    logic          out_free;
    logic          out_load;
    bfb_out_t      out_next;
    bfb_wr_t       wr;
    logic          map_re;
    logic          adv_re;
    logic [7:0]    map_rdata;
    logic [7:0]    adv_rdata;
    logic [15:0]   adv_ext;
    logic          glyph_skip;
    logic [GADDR_W-1:0] glyph_raddr;
    logic [7:0]    glyph_rdata;
    bfb_scan_cmd_t scan_cmd;
    bfb_pix_t      pix;
    logic          pix_grant;
    logic          scan_done;

    assign s_ready  = (state_reg == T_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // band test: pos_y within bottom and pos_y + 8 above top
    assign band_ok = (s_data.pos_y <= band_bottom_reg) &&
                     (({1'b0, s_data.pos_y} + BAND_MARGIN) > {1'b0, band_top_reg});

    // table writes with range checks
    assign wr.map_we   = s_fire && (s_data.func == FUNC_LOAD_MAP) &&
                         (s_data.index[9:8] == 2'b00);
    assign wr.adv_we   = s_fire && (s_data.func == FUNC_LOAD_ADV) &&
                         ({2'b00, s_data.index} < 12'(GLYPH_COUNT));
    assign wr.glyph_we = s_fire && (s_data.func == FUNC_LOAD_GLYPH) &&
                         ({2'b00, s_data.index} < 12'(GSTORE));
    assign wr.index    = s_data.index;
    assign wr.data     = s_data.value;

    assign map_re     = s_fire;
    assign glyph_skip = ({1'b0, map_rdata} >= 9'(GLYPH_COUNT));
    assign adv_ext    = {{8{adv_rdata[7]}}, adv_rdata};

    assign pix_grant  = out_free && (state_reg == T_SCAN);

    bfb_font_mem #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_mem (
        .aclk        (aclk),
        .wr          (wr),
        .map_re      (map_re),
        .map_raddr   (s_data.value),
        .map_rdata   (map_rdata),
        .adv_re      (adv_re),
        .adv_raddr   (map_rdata[GI_W-1:0]),
        .adv_rdata   (adv_rdata),
        .glyph_raddr (glyph_raddr),
        .glyph_rdata (glyph_rdata)
    );

    bfb_glyph_scan #(
        .LINE_PITCH  (LINE_PITCH),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (scan_cmd),
        .glyph       (map_rdata[GI_W-1:0]),
        .glyph_raddr (glyph_raddr),
        .glyph_rdata (glyph_rdata),
        .pix         (pix),
        .pix_grant   (pix_grant),
        .done        (scan_done)
    );

    // request sequencer
    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        width_next      = width_reg;
        ink_next        = ink_reg;
        active_next     = active_reg;
        prod_next       = prod_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        adv_re          = 1'b0;
        scan_cmd.start  = 1'b0;
        scan_cmd.cursor = cursor_reg;
        out_load        = 1'b0;
        out_next        = '0;
        unique case (state_reg)
            T_IDLE: begin
                if (s_fire) begin
                    case (s_data.func)
                        FUNC_START: begin
                            width_next = '0;
                            ink_next   = s_data.color;
                            if (band_ok) begin
                                prod_next   = 16'(s_data.pos_x);
                                mcand_next  = 16'(LINE_PITCH);
                                mplier_next = s_data.pos_y;
                                state_next  = T_MUL;
                            end else begin
                                active_next = 1'b0;
                            end
                        end
                        FUNC_CHAR: begin
                            if (s_data.value == END_CHAR) begin
                                active_next = 1'b0;
                                state_next  = T_FIN;
                            end else if (active_reg) begin
                                if (s_data.value == SPACE_CHAR) begin
                                    cursor_next = cursor_reg + SPACE_STEP;
                                end else begin
                                    state_next = T_MAP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            T_MUL: begin
                // one multiplier bit per cycle, ends once no set bits remain
                if (mplier_reg[0]) begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[14:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[7:1]};
                if (mplier_reg[7:1] == 7'd0) begin
                    cursor_next = prod_next;
                    active_next = 1'b1;
                    state_next  = T_IDLE;
                end
            end
            T_MAP: begin
                if (glyph_skip) begin
                    state_next = T_IDLE;
                end else begin
                    adv_re         = 1'b1;
                    scan_cmd.start = 1'b1;
                    state_next     = T_SCAN;
                end
            end
            T_SCAN: begin
                if (pix.valid && out_free) begin
                    out_load              = 1'b1;
                    out_next.kind         = KIND_PIXEL;
                    out_next.pixel_offset = pix.offset;
                    out_next.pixel_color  = ink_reg;
                    out_next.last         = pix.last;
                end
                if (scan_done) begin
                    cursor_next = cursor_reg + adv_ext;
                    width_next  = width_reg + adv_ext;
                    state_next  = T_IDLE;
                end
            end
            T_FIN: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.kind       = KIND_FINISH;
                    out_next.draw_width = width_reg;
                    out_next.last       = 1'b1;
                    state_next          = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    // string state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_IDLE;
            cursor_reg <= '0;
            width_reg  <= '0;
            ink_reg    <= '0;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            width_reg  <= width_next;
            ink_reg    <= ink_next;
            active_reg <= active_next;
        end
    end

    // shift-and-add cursor product
    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // band registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_top_reg    <= '0;
            band_bottom_reg <= BAND_BOTTOM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BAND_TOP:    band_top_reg    <= cfg_wdata;
                REG_BAND_BOTTOM: band_bottom_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    `BFB_ASSERT_NOW(a_pix_in_scan, aclk, aresetn, pix.valid, state_reg == T_SCAN, "pixel offered outside glyph scan")
    `BFB_ASSERT_NOW(a_pix_no_width, aclk, aresetn, m_valid_reg && m_data_reg.kind == KIND_PIXEL, m_data_reg.draw_width == 16'd0, "pixel result carries a width")
    `BFB_ASSERT_NOW(a_fin_last, aclk, aresetn, m_valid_reg && m_data_reg.kind == KIND_FINISH, m_data_reg.last && m_data_reg.pixel_offset == 16'd0, "finish result malformed")

endmodule

// ===== dv/bitmap_font_text_blitter_test.sv =====
// bitmap_font_text_blitter_test: self-checking bench for the text blitter, with a request
// driver, a result monitor and a built-in glyph blit predictor
// depends on bfb_pkg and the bitmap_font_text_blitter rtl
`timescale 1ns / 1ps

module bitmap_font_text_blitter_test import bfb_pkg::*;;

    localparam int PITCH        = 320;
    localparam int ROWS         = 8;
    localparam int GLYPHS       = 128;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES       = 5;
    localparam logic [2:0] FUNC_SPARE_FIRST = FUNC_CHAR + 3'd1;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    bfb_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    bfb_out_t             m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;

    bitmap_font_text_blitter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state: font tables, string state and band limits
    logic [7:0]  font_map   [256];
    logic [7:0]  adv_tab    [GLYPHS];
    logic [7:0]  glyph_rows [GLYPHS*ROWS];
    logic [15:0] cursor     = '0;
    logic [15:0] width_sum  = '0;
    logic [7:0]  ink        = '0;
    bit          string_on  = 1'b0;
    logic [7:0]  top_row    = '0;
    logic [7:0]  bottom_row = BAND_BOTTOM_RESET;

    // which table entries the stimulus has filled, so no unwritten entry is read
    bit [255:0]         map_loaded  = '0;
    bit [GLYPHS-1:0]    adv_loaded  = '0;
    bit [GLYPHS*ROWS-1:0] rows_loaded = '0;
    bit [GLYPHS-1:0]    glyph_ready = '0;

    bfb_in_t  request_backlog [$];
    bfb_out_t pending_blits   [$];
    int requests_posted = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    // predictor for one accepted request: table loads, string state, expected pixel writes and finish results
    function automatic void blit_predict(bfb_in_t req);
        logic [7:0]  g;
        logic [7:0]  bits;
        logic [15:0] step;
        bfb_out_t    held;
        bit          have_held;
        have_held = 1'b0;
        held = '0;
        case (req.func)
            FUNC_LOAD_MAP: begin
                if (req.index < 256) font_map[req.index[7:0]] = req.value;
            end
            FUNC_LOAD_ADV: begin
                if (req.index < GLYPHS) adv_tab[req.index[6:0]] = req.value;
            end
            FUNC_LOAD_GLYPH: begin
                if (req.index < GLYPHS*ROWS) glyph_rows[req.index] = req.value;
            end
            FUNC_START: begin
                width_sum = '0;
                ink = req.color;
                if (int'(req.pos_y) > int'(bottom_row) ||
                    int'(req.pos_y) <= int'(top_row) - 8) begin
                    string_on = 1'b0;
                end else begin
                    string_on = 1'b1;
                    cursor = 16'(int'(req.pos_y) * PITCH + int'(req.pos_x));
                end
            end
            FUNC_CHAR: begin
                if (req.value == END_CHAR) begin
                    string_on = 1'b0;
                    held.kind = KIND_FINISH;
                    held.draw_width = width_sum;
                    held.last = 1'b1;
                    pending_blits.push_back(held);
                end else if (!string_on) begin
                    // no string open, byte dropped
                end else if (req.value == SPACE_CHAR) begin
                    cursor = cursor + SPACE_STEP;
                end else begin
                    g = font_map[req.value];
                    if (!g[7] && int'(g) < GLYPHS) begin
                        step = {{8{adv_tab[g[6:0]][7]}}, adv_tab[g[6:0]]};
                        // rows top down, columns msb first; each pixel held to mark the last
                        for (int r = 0; r < ROWS; r++) begin
                            bits = glyph_rows[int'(g) * ROWS + r];
                            for (int c = 0; c < 8; c++) begin
                                if (bits[7-c]) begin
                                    if (have_held) pending_blits.push_back(held);
                                    held = '0;
                                    held.kind = KIND_PIXEL;
                                    held.pixel_offset = 16'(int'(cursor) + r * PITCH + c);
                                    held.pixel_color = ink;
                                    have_held = 1'b1;
                                end
                            end
                        end
                        if (have_held) begin
                            held.last = 1'b1;
                            pending_blits.push_back(held);
                        end
                        cursor = cursor + step;
                        width_sum = width_sum + step;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                blit_predict(s_data);
                requests_taken++;
                if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, 3);
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    s_data  <= request_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result monitor with random receiver stalls
    always @(posedge aclk) begin
        bfb_out_t want;
        bit       rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            rdy = m_ready;
            if (m_valid && m_ready) begin
                if (pending_blits.size() == 0) begin
                    $error("result with none expected: kind %0d offset 0x%0h width 0x%0h",
                           m_data.kind, m_data.pixel_offset, m_data.draw_width);
                    mismatches++;
                end else begin
                    want = pending_blits.pop_front();
                    check_field("kind", want.kind, m_data.kind);
                    check_field("pixel_offset", want.pixel_offset, m_data.pixel_offset);
                    check_field("pixel_color", want.pixel_color, m_data.pixel_color);
                    check_field("draw_width", want.draw_width, m_data.draw_width);
                    check_field("last", want.last, m_data.last);
                    results_checked++;
                end
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
                rdy = (recv_wait == 0);
            end else if (!m_ready) begin
                if (recv_wait > 0) recv_wait--;
                rdy = (recv_wait == 0);
            end
            m_ready <= rdy;
        end
    end

    // request builders; loads also update which entries are safe to read
    task automatic queue_request(bfb_in_t r);
        int g;
        if (r.func == FUNC_LOAD_MAP && r.index < 256) map_loaded[r.index[7:0]] = 1'b1;
        if (r.func == FUNC_LOAD_ADV && r.index < GLYPHS) adv_loaded[r.index[6:0]] = 1'b1;
        if (r.func == FUNC_LOAD_GLYPH) rows_loaded[r.index] = 1'b1;
        if (r.func == FUNC_LOAD_ADV || r.func == FUNC_LOAD_GLYPH) begin
            g = (r.func == FUNC_LOAD_ADV) ? int'(r.index) : int'(r.index) / ROWS;
            if (g < GLYPHS) glyph_ready[g] = adv_loaded[g] && (&rows_loaded[g*ROWS +: ROWS]);
        end
        request_backlog.push_back(r);
        requests_posted++;
    endtask

    task automatic post(logic [2:0] f, int idx, int val);
        bfb_in_t     r;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        r = noise[$bits(bfb_in_t)-1:0];
        r.func  = f;
        r.index = idx[9:0];
        r.value = val[7:0];
        queue_request(r);
    endtask

    task automatic post_start(int px, int py, int col);
        bfb_in_t     r;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        r = noise[$bits(bfb_in_t)-1:0];
        r.func  = FUNC_START;
        r.pos_x = px[8:0];
        r.pos_y = py[7:0];
        r.color = col[7:0];
        queue_request(r);
    endtask

    task automatic load_glyph(int g, logic [7:0] adv, logic [63:0] rows);
        post(FUNC_LOAD_ADV, g, adv);
        for (int r = 0; r < ROWS; r++) post(FUNC_LOAD_GLYPH, g * ROWS + r, rows[63-8*r -: 8]);
    endtask

    // map value: a skipped code or a fully loaded glyph
    function automatic int glyph_ref();
        int opts[$];
        if ($urandom_range(0, 3) == 0) return $urandom_range(128, 255);
        for (int g = 0; g < GLYPHS; g++) if (glyph_ready[g]) opts.push_back(g);
        if (opts.size() == 0) return 8'h80;
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    // text byte whose map entry is loaded, or a space
    function automatic int text_byte();
        int opts[$];
        if ($urandom_range(0, 4) == 0) return SPACE_CHAR;
        for (int b = 1; b < 256; b++) if (map_loaded[b] && b != SPACE_CHAR) opts.push_back(b);
        if (opts.size() == 0) return SPACE_CHAR;
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    task automatic random_phase(int n);
        int first, k, lo, hi, py, px, pick;
        first = requests_posted;
        while (requests_posted - first < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // a string: start near the band, a few bytes, usually a terminator
                lo = int'(top_row) - 8;
                if (lo < 0) lo = 0;
                hi = bottom_row;
                if ($urandom_range(0, 4) != 0 && lo <= hi) py = $urandom_range(lo, hi);
                else py = $urandom_range(0, 255);
                px = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 319);
                post_start(px, py, $urandom_range(0, 255));
                k = $urandom_range(1, 5);
                repeat (k) post(FUNC_CHAR, $urandom_range(0, 1023), text_byte());
                if ($urandom_range(0, 7) != 0) post(FUNC_CHAR, $urandom_range(0, 1023), END_CHAR);
            end else if (pick < 63) begin
                load_glyph($urandom_range(0, GLYPHS - 1), 8'($urandom_range(0, 255)),
                           {$urandom, $urandom});
            end else if (pick < 72) begin
                post(FUNC_LOAD_GLYPH, $urandom_range(0, 1023), $urandom_range(0, 255));
            end else if (pick < 85) begin
                post(FUNC_LOAD_MAP, $urandom_range(0, 255), glyph_ref());
            end else if (pick < 90) begin
                post(FUNC_LOAD_ADV, $urandom_range(0, GLYPHS - 1), $urandom_range(0, 255));
            end else if (pick < 93) begin
                // loads past the end of their table
                if ($urandom_range(0, 1) == 0) post(FUNC_LOAD_MAP, $urandom_range(256, 1023), $urandom_range(0, 255));
                else post(FUNC_LOAD_ADV, $urandom_range(GLYPHS, 1023), $urandom_range(0, 255));
            end else if (pick < 96) begin
                post(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                     $urandom_range(0, 1023), $urandom_range(0, 255));
            end else begin
                // stray text byte or terminator with no start of its own
                post(FUNC_CHAR, $urandom_range(0, 1023),
                     ($urandom_range(0, 1) == 0) ? int'(END_CHAR) : text_byte());
            end
        end
    endtask

    // block idle: all requests taken and all results seen, then a settle wait
    task automatic wait_idle();
        while (requests_taken != requests_posted || pending_blits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_band(logic [7:0] top, logic [7:0] bottom);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BAND_TOP;
        cfg_wdata <= top;
        @(posedge aclk);
        cfg_index <= REG_BAND_BOTTOM;
        cfg_wdata <= bottom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        top_row = top;
        bottom_row = bottom;
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // font: full block, signed extreme advance, empty glyph with negative advance
        load_glyph(0, 8'h7F, {8{8'hFF}});
        load_glyph(GLYPHS - 1, 8'h80, 64'h80_01_00_AA_55_FF_00_81);
        load_glyph(5, 8'hFA, 64'h0);
        post(FUNC_LOAD_MAP, 8'hFF, 0);
        post(FUNC_LOAD_MAP, 8'h01, GLYPHS - 1);
        post(FUNC_LOAD_MAP, 8'h41, 5);
        post(FUNC_LOAD_MAP, 8'h80, 8'h80);
        post(FUNC_LOAD_MAP, 8'h7F, 8'hFF);

        // ignored requests and loads beyond their tables
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) post(3'(f), 1023, 255);
        post(FUNC_LOAD_MAP, 1023, 8'h55);
        post(FUNC_LOAD_ADV, GLYPHS, 8'h55);

        // terminator with no string, rejected start, byte while inactive
        post(FUNC_CHAR, 0, END_CHAR);
        post_start(511, 255, 255);
        post(FUNC_CHAR, 0, 8'h01);

        // bottom-right start so glyph rows wrap the address
        post_start(319, 199, 8'hAA);
        post(FUNC_CHAR, 1023, 8'hFF);
        post(FUNC_CHAR, 0, 8'h01);
        post(FUNC_CHAR, 0, SPACE_CHAR);
        post(FUNC_CHAR, 0, 8'h80);
        post(FUNC_CHAR, 0, 8'h7F);
        post(FUNC_CHAR, 0, 8'h41);
        post(FUNC_CHAR, 0, END_CHAR);

        // origin start with negative advances wrapping cursor and width
        post_start(0, 0, 0);
        post(FUNC_CHAR, 0, 8'h01);
        post(FUNC_CHAR, 0, 8'h01);
        post(FUNC_CHAR, 0, END_CHAR);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: write_band(8'd199, 8'd199);
                2: write_band(8'd0, 8'd0);
                3: write_band(8'd100, 8'd255);
                default: write_band(8'd8, 8'd40);
            endcase
            random_phase(20);
            wait_idle();
        end

        $display("checked %0d results from %0d requests across %0d band settings",
                 results_checked, requests_taken, PHASES);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bfb_pkg.sv
sv/bfb_font_mem.sv
sv/bfb_glyph_scan.sv
sv/bitmap_font_text_blitter.sv
dv/bitmap_font_text_blitter_test.sv
